[sv/wrench_deadzone_lowpass_macros.svh]
// ---------------------------------------------------------------------------
// wrench_deadzone_lowpass_macros.svh
// Assertion shorthands for the wrench conditioning block
// ---------------------------------------------------------------------------
`ifndef WRENCH_DEADZONE_LOWPASS_MACROS_SVH
`define WRENCH_DEADZONE_LOWPASS_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wdl_pkg.sv]
// ---------------------------------------------------------------------------
// wdl_pkg
// Shared codes for the wrench deadzone / low-pass block
// ---------------------------------------------------------------------------
`default_nettype none

package wdl_pkg;

  // configuration register index width
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER_THRESHOLD = 2'd0,
    CFG_UPPER_THRESHOLD = 2'd1,
    CFG_FILTER_COEFF    = 2'd2
  } cfg_idx_t;

  // number of filtered force axes
  localparam int unsigned NUM_FORCE_AXES = 3;

endpackage

`default_nettype wire

[sv/wdl_axis.sv]
// ---------------------------------------------------------------------------
// wdl_axis
// One force axis: band check, deadzone, exponential average and its state
// ---------------------------------------------------------------------------
`default_nettype none

module wdl_axis #(
  parameter int unsigned SAMPLE_WIDTH    = 16,
  parameter int unsigned COEFF_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    force_in,
  input  wire logic        [SAMPLE_WIDTH-2:0]    lower_threshold,
  input  wire logic        [SAMPLE_WIDTH-2:0]    upper_threshold,
  input  wire logic        [COEFF_FRAC_BITS:0]   filter_coeff,
  input  wire logic                              update,
  output logic signed      [SAMPLE_WIDTH-1:0]    force_out
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned F     = COEFF_FRAC_BITS;
  localparam int unsigned ACC_W = SW + F + 5;

  logic signed [SW-1:0]    prev_r;
  logic signed [SW-1:0]    prev_nxt;
  logic        [SW-1:0]    mag;
  logic                    in_band;
  logic                    is_pos;
  logic signed [SW:0]      x_ext;
  logic signed [SW:0]      lower_ext;
  logic signed [SW:0]      dz_val;
  logic signed [SW+1:0]    diff;
  logic signed [F+1:0]     coeff_s;
  logic signed [F+SW+3:0]  prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [SW-1:0]    filt;

  // magnitude; the most negative code wraps to 2^(SW-1) as unsigned
  assign mag     = force_in[SW-1] ? SW'(-force_in) : force_in;
  assign in_band = (mag >= {1'b0, lower_threshold}) && (mag <= {1'b0, upper_threshold});

  // pull toward zero by the lower threshold
  assign is_pos    = !force_in[SW-1] && (force_in != '0);
  assign x_ext     = (SW+1)'(force_in);
  assign lower_ext = $signed({2'b00, lower_threshold});
  assign dz_val    = is_pos ? (x_ext - lower_ext) : (x_ext + lower_ext);

  // prev + a*(v - prev), rounded, floor shift
  assign diff    = (SW+2)'(dz_val) - (SW+2)'(prev_r);
  assign coeff_s = $signed({1'b0, filter_coeff});
  assign prod    = coeff_s * diff;
  assign acc     = (ACC_W'(prev_r) <<< F) + ACC_W'(prod)
                   + (ACC_W'(1) <<< (F - 1));
  assign filt    = acc[F+SW-1:F];

  assign force_out = in_band ? filt : '0;

  // state follows only passing samples
  assign prev_nxt = (update && in_band) ? filt : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/wrench_deadzone_lowpass.sv]
// ---------------------------------------------------------------------------
// wrench_deadzone_lowpass
// Six-axis force/torque conditioning: deadzone, band limit, low-pass on forces
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) takes one wrench sample per beat;
//   the output channel (out_valid / out_stall) gives one conditioned sample
//   per beat, in order. Torques pass through; each force axis is banded,
//   shifted by the lower threshold and run through an exponential average.
//   From an input beat to out_valid the sample passes an input register,
//   then single-pass logic (one multiply-add per axis), then the output
//   register. Throughput is one sample per cycle while out_stall is low,
//   set by that multiply-add feeding the per-axis state register.
//   A stalled result is held in the output register while one more sample
//   waits in the input register; in_stall rises only when both are full.
//   Configuration (cfg_we / cfg_index / cfg_wdata) must be written only
//   while idle, unenforced by the block; a coefficient above 1.0 saturates,
//   unused indexes are ignored. Synchronous reset clears both stages, the
//   filter states and loads the thresholds 7.0 / 160.0 and coefficient 0.75.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wrench_deadzone_lowpass_macros.svh"

module wrench_deadzone_lowpass #(
  parameter int unsigned SAMPLE_WIDTH    = 16,
  parameter int unsigned COEFF_FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [wdl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [((SAMPLE_WIDTH-1 > COEFF_FRAC_BITS+1) ?
                      SAMPLE_WIDTH-1 : COEFF_FRAC_BITS+1)-1:0] cfg_wdata,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_force_x_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_force_y_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_force_z_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_torque_x_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_torque_y_in,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_torque_z_in,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]            out_force_x_out,
  output logic signed [SAMPLE_WIDTH-1:0]            out_force_y_out,
  output logic signed [SAMPLE_WIDTH-1:0]            out_force_z_out,
  output logic signed [SAMPLE_WIDTH-1:0]            out_torque_x_out,
  output logic signed [SAMPLE_WIDTH-1:0]            out_torque_y_out,
  output logic signed [SAMPLE_WIDTH-1:0]            out_torque_z_out
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned TW   = SAMPLE_WIDTH - 1;
  localparam int unsigned CW   = COEFF_FRAC_BITS + 1;
  localparam int unsigned NAX  = wdl_pkg::NUM_FORCE_AXES;
  localparam int unsigned THRESH_MAX = (1 << TW) - 1;

  localparam logic [TW-1:0] LOWER_RESET = TW'((896 > THRESH_MAX) ? THRESH_MAX : 896);
  localparam logic [TW-1:0] UPPER_RESET = TW'((20480 > THRESH_MAX) ? THRESH_MAX : 20480);
  localparam logic [CW-1:0] COEFF_ONE   = CW'(1) << COEFF_FRAC_BITS;
  localparam logic [CW-1:0] COEFF_RESET = CW'(3) << (COEFF_FRAC_BITS - 2);

  // configuration registers
  logic [TW-1:0] lower_r, lower_nxt;
  logic [TW-1:0] upper_r, upper_nxt;
  logic [CW-1:0] coeff_r, coeff_nxt;
  logic [CW-1:0] coeff_wr;

  // pipeline stages
  logic                         s1_valid_r, s1_valid_nxt;
  logic signed [NAX-1:0][SW-1:0] s1_force_r;
  logic signed [NAX-1:0][SW-1:0] s1_torque_r;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [NAX-1:0][SW-1:0] out_force_r;
  logic signed [NAX-1:0][SW-1:0] out_torque_r;
  logic signed [NAX-1:0][SW-1:0] force_cond;
  logic                         advance;
  logic                         in_take;

  // register writes, coefficient saturated at one
  assign coeff_wr = (cfg_wdata[CW-1:0] > COEFF_ONE) ? COEFF_ONE : cfg_wdata[CW-1:0];

  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    coeff_nxt = coeff_r;
    if (cfg_we) begin
      unique case (wdl_pkg::cfg_idx_t'(cfg_index))
        wdl_pkg::CFG_LOWER_THRESHOLD: lower_nxt = cfg_wdata[TW-1:0];
        wdl_pkg::CFG_UPPER_THRESHOLD: upper_nxt = cfg_wdata[TW-1:0];
        wdl_pkg::CFG_FILTER_COEFF:    coeff_nxt = coeff_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
      coeff_r <= COEFF_RESET;
    end else begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      coeff_r <= coeff_nxt;
    end
  end

  // handshake: stage one moves on when the output register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_force_r[0]  <= in_force_x_in;
      s1_force_r[1]  <= in_force_y_in;
      s1_force_r[2]  <= in_force_z_in;
      s1_torque_r[0] <= in_torque_x_in;
      s1_torque_r[1] <= in_torque_y_in;
      s1_torque_r[2] <= in_torque_z_in;
    end
  end

  // per-axis conditioning
  for (genvar g = 0; g < NAX; g++) begin : g_axis
    wdl_axis #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_axis (
      .clk             (clk),
      .rst_n           (rst_n),
      .force_in        (s1_force_r[g]),
      .lower_threshold (lower_r),
      .upper_threshold (upper_r),
      .filter_coeff    (coeff_r),
      .update          (advance),
      .force_out       (force_cond[g])
    );
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_force_r  <= force_cond;
      out_torque_r <= s1_torque_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_force_x_out  = out_force_r[0];
  assign out_force_y_out  = out_force_r[1];
  assign out_force_z_out  = out_force_r[2];
  assign out_torque_x_out = out_torque_r[0];
  assign out_torque_y_out = out_torque_r[1];
  assign out_torque_z_out = out_torque_r[2];

  // checks
  `WDL_ASSERT_NOW(a_full_stalls, clk, rst_n, s1_valid_r && out_valid_r && out_stall, in_stall, "input not stalled with both stages full")
  `WDL_ASSERT_NEXT(a_torque_pass, clk, rst_n, advance, out_valid_r && (out_torque_r[0] == $past(s1_torque_r[0])), "torque beat not carried to output")
  `WDL_ASSERT_NEXT(a_drain_empty, clk, rst_n, out_valid_r && !out_stall && !s1_valid_r, !out_valid_r, "output valid without a pending beat")
  `WDL_ASSERT_NEXT(a_hold_stage, clk, rst_n, s1_valid_r && !advance, s1_valid_r && $stable(s1_force_r), "stalled stage one beat lost or changed")

endmodule

`default_nettype wire
